// File: hw/rtl/nram_pkg.sv
// Shared types and constants for the nearest region anchor map.
package nram_pkg;

    localparam int REGIONS = 64;
    localparam int IDX_W = 6;
    localparam int FRAC_W = 16;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 16'd64880;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;
    localparam logic [1:0] MODE_PIXEL = 2'd3;

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_APPROX = 2'd1;

    typedef struct packed {
        logic [31:0] src_begin;
        logic [31:0] src_end;
        logic [1:0]  quality;
        logic [23:0] top;
        logic [15:0] height;
    } entry_t;

    typedef struct packed {
        logic        mode_pixel;
        logic [31:0] anchor_byte;
        logic [23:0] query_y;
    } query_t;

    // Candidate moving down the cell chain.
    typedef struct packed {
        logic        found;
        logic [32:0] gap;
        logic [31:0] span;
        entry_t      ent;
    } cand_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_index;
        entry_t      ent;
    } cmd_t;

endpackage

// File: hw/rtl/nram_cell.sv
// One table entry plus a compare stage of the scan chain.
module nram_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic            clr_en,
    input  nram_pkg::entry_t wr_data,
    input  logic            shift_en,
    input  nram_pkg::query_t qry,
    input  nram_pkg::cand_t  cand_in,
    output nram_pkg::cand_t  cand_out
);
    nram_pkg::entry_t ent_reg;
    logic [1:0] qual_reg;
    nram_pkg::cand_t cand_reg, cand_next;
    nram_pkg::entry_t ent_v;
    logic [32:0] d;
    logic [31:0] span;
    logic signed [24:0] y, s, e;
    logic take;

    always_comb begin
        ent_v = ent_reg;
        ent_v.quality = qual_reg;
        y = {qry.query_y[23], qry.query_y};
        s = {ent_reg.top[23], ent_reg.top};
        e = s + $signed({9'd0, ent_reg.height});
        span = ent_reg.src_end - ent_reg.src_begin;
        if (qry.mode_pixel) begin
            if (y < s) d = {{8{1'b0}}, 25'(s - y)};
            else if (y >= e) d = {{8{1'b0}}, 25'(y - e + 25'sd1)};
            else d = '0;
        end else begin
            if (qry.anchor_byte < ent_reg.src_begin)
                d = {1'b0, ent_reg.src_begin - qry.anchor_byte};
            else if (qry.anchor_byte >= ent_reg.src_end)
                d = {1'b0, qry.anchor_byte - ent_reg.src_end} + 33'd1;
            else d = '0;
        end
        take = 1'b0;
        if (qual_reg != nram_pkg::Q_NONE) begin
            if (!cand_in.found || d < cand_in.gap) take = 1'b1;
            else if (d == cand_in.gap) begin
                if (qry.mode_pixel) begin
                    if (ent_reg.height < cand_in.ent.height) take = 1'b1;
                    else if (ent_reg.height == cand_in.ent.height &&
                             ent_reg.src_begin < cand_in.ent.src_begin) take = 1'b1;
                end else if (span < cand_in.span) begin
                    take = 1'b1;
                end
            end
        end
        cand_next = cand_in;
        if (take) begin
            cand_next.found = 1'b1;
            cand_next.gap = d;
            cand_next.span = span;
            cand_next.ent = ent_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qual_reg <= nram_pkg::Q_NONE;
            cand_reg.found <= 1'b0;
        end else begin
            if (clr_en) qual_reg <= nram_pkg::Q_NONE;
            else if (wr_en) qual_reg <= wr_data.quality;
            if (shift_en) cand_reg.found <= cand_next.found;
        end
        if (wr_en) ent_reg <= wr_data;
        if (shift_en) begin
            cand_reg.gap  <= cand_next.gap;
            cand_reg.span <= cand_next.span;
            cand_reg.ent  <= cand_next.ent;
        end
    end

    assign cand_out = cand_reg;
endmodule

// File: hw/rtl/nram_arith.sv
// Serial multiply / divide that turns the winning entry into a result.
module nram_arith (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             mode_pixel,
    input  logic [15:0]      anchor_fraction,
    input  logic [23:0]      query_y,
    input  nram_pkg::cand_t  cand,
    output logic             done,
    output logic [23:0]      out_y,
    output logic [31:0]      out_byte,
    output logic [15:0]      out_fraction,
    output logic [1:0]       out_quality
);
    typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} astate_t;
    astate_t st_reg;
    logic [5:0] cnt_reg;
    logic [40:0] acc_reg;   // multiply: product; divide: remainder
    logic [40:0] num_reg;   // divide: numerator shift / multiply: multiplicand
    logic [15:0] mul_reg;
    logic [16:0] quo_reg;
    logic [16:0] dvs_reg;
    logic pix_reg, neg_reg;
    nram_pkg::cand_t c_reg;
    logic [15:0] f_cl;
    logic signed [24:0] dy;
    logic [41:0] rem_sh;
    logic signed [25:0] row;

    always_comb begin
        f_cl = (anchor_fraction > nram_pkg::FRAC_MAX) ? nram_pkg::FRAC_MAX
                                                         : anchor_fraction;
        dy = $signed({query_y[23], query_y}) - $signed({cand.ent.top[23], cand.ent.top});
        rem_sh = {acc_reg, num_reg[40]};
        row = $signed({c_reg.ent.top[23], c_reg.ent.top[23], c_reg.ent.top})
              + $signed({10'd0, acc_reg[31:16]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= A_IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (st_reg)
                A_IDLE: begin
                    if (start) begin
                        c_reg <= cand;
                        pix_reg <= mode_pixel;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        neg_reg <= dy[24];
                        quo_reg <= '0;
                        mul_reg <= f_cl;
                        dvs_reg <= (cand.ent.height == 16'd0) ? 17'd1
                                                               : {1'b0, cand.ent.height};
                        num_reg <= mode_pixel ? {dy[23:0], 17'd0}
                                              : {25'd0, cand.ent.height};
                        st_reg <= A_RUN;
                    end
                end
                A_RUN: begin
                    if (pix_reg) begin
                        // 40 quotient bits; restore one bit a step
                        if (rem_sh >= {25'd0, dvs_reg}) begin
                            acc_reg <= 41'(rem_sh - {25'd0, dvs_reg});
                            quo_reg <= quo_reg[16] ? '1 : {quo_reg[15:0], 1'b1};
                        end else begin
                            acc_reg <= rem_sh[40:0];
                            quo_reg <= quo_reg[16] ? '1 : {quo_reg[15:0], 1'b0};
                        end
                        num_reg <= {num_reg[39:0], 1'b0};
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd39) st_reg <= A_FIN;
                    end else begin
                        if (mul_reg[0]) acc_reg <= acc_reg + num_reg;
                        mul_reg <= mul_reg >> 1;
                        num_reg <= num_reg << 1;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd15) st_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    done <= 1'b1;
                    st_reg <= A_IDLE;
                end
                default: st_reg <= A_IDLE;
            endcase
        end
    end

    logic [23:0] y_res;
    logic [15:0] f_res;
    always_comb begin
        y_res = row[25] ? 24'd0 : row[23:0];
        f_res = (neg_reg || quo_reg[16]) ? (neg_reg ? 16'd0 : nram_pkg::FRAC_MAX)
              : ((quo_reg[15:0] > nram_pkg::FRAC_MAX) ? nram_pkg::FRAC_MAX
                                                       : quo_reg[15:0]);
        out_y = '0; out_byte = '0; out_fraction = '0; out_quality = nram_pkg::Q_NONE;
        if (c_reg.found) begin
            out_quality = (c_reg.gap == '0) ? c_reg.ent.quality : nram_pkg::Q_APPROX;
            if (pix_reg) begin
                out_byte = c_reg.ent.src_begin;
                out_fraction = f_res;
            end else begin
                out_y = y_res;
            end
        end
    end
endmodule

// File: hw/rtl/nearest_region_anchor_map_top.sv
// Top level of the nearest region anchor map.
// Usage:
//   s_axis carries one command per transfer: mode 0 writes an entry, mode 1
//   clears all qualities, mode 2 is a byte query, mode 3 a pixel query.
//   Writes and clears give no result.
//   Each query gives one transfer on m_axis.
// Operation:
//   A query passes the 64-cell scan chain, then a serial unit:
//   16 shift-add steps for a byte query, 40 restoring divide steps for a
//   pixel query. s_axis_tready returns in the cycle after the result
//   transfer. One query at a time; scan chain and serial unit set it.
// Reset: aresetn low clears all qualities, so every entry is unusable.
// Stall: the result waits in the output register while m_axis_tready is low;
//   s_axis_tready stays low until the next item may start.
module nearest_region_anchor_map_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], entry_index[7:2], src_begin[39:8], src_end[71:40],
    // src_quality[73:72], region_top[97:74], region_height[113:98],
    // anchor_byte[145:114], anchor_fraction[161:146], query_y[185:162]
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_y[23:0], out_byte[55:24], out_fraction[71:56], out_quality[73:72]
    output logic [79:0]  m_axis_tdata
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ARITH, S_WAIT, S_OUT} state_t;
    state_t st_reg;
    logic [6:0] cnt_reg;
    logic [191:0] in_reg;
    nram_pkg::cand_t chain [nram_pkg::REGIONS+1];
    nram_pkg::query_t qry;
    nram_pkg::entry_t wdat;
    logic acc, wr, clr, shift_en, arith_done;
    logic [23:0] a_y; logic [31:0] a_b; logic [15:0] a_f; logic [1:0] a_q;

    assign s_axis_tready = (st_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign wr = acc && s_axis_tdata[1:0] == nram_pkg::MODE_WRITE;
    assign clr = acc && s_axis_tdata[1:0] == nram_pkg::MODE_CLEAR;
    assign shift_en = (st_reg == S_SCAN);
    assign wdat = '{src_begin: s_axis_tdata[39:8], src_end: s_axis_tdata[71:40],
                    quality: s_axis_tdata[73:72], top: s_axis_tdata[97:74],
                    height: s_axis_tdata[113:98]};
    assign qry = '{mode_pixel: in_reg[0], anchor_byte: in_reg[145:114],
                   query_y: in_reg[185:162]};
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < nram_pkg::REGIONS; g++) begin : g_cell
            nram_cell u_cell (
                .aclk, .aresetn,
                .wr_en(wr && s_axis_tdata[7:2] == nram_pkg::IDX_W'(g)),
                .clr_en(clr), .wr_data(wdat), .shift_en, .qry,
                .cand_in(chain[g]), .cand_out(chain[g+1])
            );
        end
    endgenerate

    nram_arith u_arith (
        .aclk, .aresetn, .start(st_reg == S_ARITH), .mode_pixel(in_reg[0]),
        .anchor_fraction(in_reg[161:146]), .query_y(in_reg[185:162]),
        .cand(chain[nram_pkg::REGIONS]), .done(arith_done),
        .out_y(a_y), .out_byte(a_b), .out_fraction(a_f), .out_quality(a_q)
    );

    // cells latch only on shift; each stage sees the candidate of the previous
    // cell in the cycle after it latches; the scan fills the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            m_axis_tvalid <= 1'b0;
        end else begin
            case (st_reg)
                S_IDLE: begin
                    if (acc && s_axis_tdata[1]) begin
                        in_reg <= s_axis_tdata;
                        cnt_reg <= '0;
                        st_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(nram_pkg::REGIONS - 1)) st_reg <= S_ARITH;
                end
                S_ARITH: st_reg <= S_WAIT;
                S_WAIT: begin
                    if (arith_done) begin
                        m_axis_tdata <= {6'd0, a_q, a_f, a_b, a_y};
                        m_axis_tvalid <= 1'b1;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
